>>> rtl/core/csvft_pkg.sv
// shared types, constants and helpers for the csv field tokenizer
`timescale 1ns / 1ps

package csvft_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_DATA      = 2'd0;
    localparam kind_t KIND_FIELD_END = 2'd1;
    localparam kind_t KIND_LINE_END  = 2'd2;
    localparam kind_t KIND_SKIPPED   = 2'd3;

    localparam logic CMD_BYTE     = 1'b0;
    localparam logic CMD_LINE_END = 1'b1;

    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    typedef enum logic [1:0] {
        MODE_UNDECIDED,
        MODE_NORMAL,
        MODE_SKIP
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_HELD,
        ST_CHAR
    } state_t;

    typedef enum logic [1:0] {
        SEL_DIRECT,
        SEL_HELD,
        SEL_CHAR
    } out_sel_t;

    typedef struct packed {
        logic     accept;
        logic     load;
        out_sel_t out_sel;
        logic     rd_en;
        logic     ptr_inc;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic has_result;
        logic flush_need;
        logic held_last;
    } dp_status_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

endpackage

>>> rtl/core/csvft_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module csvft_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 15,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/csvft_ctrl.sv
// sequencing state machine: request intake and held-space flush
`timescale 1ns / 1ps

module csvft_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  csvft_pkg::dp_status_t status,
    output csvft_pkg::ctrl_cmd_t  cmd
);

    csvft_pkg::state_t state_reg;
    csvft_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= csvft_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd.accept  = 1'b0;
        cmd.load    = 1'b0;
        cmd.out_sel = csvft_pkg::SEL_DIRECT;
        cmd.rd_en   = 1'b0;
        cmd.ptr_inc = 1'b0;
        case (state_reg)
            csvft_pkg::ST_IDLE: begin
                s_ready    = status.out_free;
                cmd.accept = s_valid && status.out_free;
                if (cmd.accept) begin
                    if (status.flush_need) begin
                        state_next = csvft_pkg::ST_READ;
                    end else begin
                        cmd.load = status.has_result;
                    end
                end
            end
            csvft_pkg::ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = csvft_pkg::ST_HELD;
            end
            csvft_pkg::ST_HELD: begin
                cmd.out_sel = csvft_pkg::SEL_HELD;
                if (status.out_free) begin
                    cmd.load    = 1'b1;
                    cmd.ptr_inc = 1'b1;
                    state_next  = status.held_last ? csvft_pkg::ST_CHAR : csvft_pkg::ST_READ;
                end
            end
            csvft_pkg::ST_CHAR: begin
                cmd.out_sel = csvft_pkg::SEL_CHAR;
                if (status.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = csvft_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = csvft_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/csvft_dp.sv
// tokenizer datapath: line state, held-space buffer and output register
`timescale 1ns / 1ps

module csvft_dp #(
    parameter int HELD_SPACE_DEPTH = 15
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic                  s_command,
    input  logic [7:0]            s_char_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_byte,
    output logic [1:0]            m_result_kind,
    output logic                  m_last_result,
    output logic                  m_ws_overflow,
    input  csvft_pkg::ctrl_cmd_t  cmd,
    output csvft_pkg::dp_status_t status
);

    localparam int CNT_W  = $clog2(HELD_SPACE_DEPTH + 1);
    localparam int ADDR_W = (HELD_SPACE_DEPTH > 1) ? $clog2(HELD_SPACE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HELD_SPACE_DEPTH);

    // line state
    logic              skip_reg;
    logic              in_quotes_reg,     in_quotes_next;
    logic              quote_pending_reg, quote_pending_next;
    logic              field_started_reg, field_started_next;
    csvft_pkg::mode_t  mode_reg,          mode_next;
    logic [CNT_W-1:0]  cnt_reg,           cnt_next;
    logic              overflow_reg,      overflow_next;

    // flush bookkeeping
    logic [CNT_W-1:0]  ptr_reg;
    logic [CNT_W-1:0]  flush_len_reg;
    logic [7:0]        char_reg;
    logic              emit_ovf_reg;

    // output register
    logic              m_valid_reg;
    logic [7:0]        m_byte_reg;
    csvft_pkg::kind_t  m_kind_reg;
    logic              m_last_reg;
    logic              m_ovf_reg;

    // decode of the current request
    logic              res_valid;
    csvft_pkg::kind_t  res_kind;
    logic [7:0]        res_byte;
    logic              res_ovf;
    logic              flush_need;
    logic              ram_we;
    logic [7:0]        ram_rdata;
    logic              c_ws;
    logic              unquoted;
    logic              is_content;
    logic              is_end;
    csvft_pkg::mode_t  mode_eff;

    assign c_ws = csvft_pkg::is_ws(s_char_byte);

    always_comb begin
        in_quotes_next     = in_quotes_reg;
        quote_pending_next = quote_pending_reg;
        field_started_next = field_started_reg;
        mode_next          = mode_reg;
        cnt_next           = cnt_reg;
        overflow_next      = overflow_reg;
        res_valid          = 1'b0;
        res_kind           = csvft_pkg::KIND_DATA;
        res_byte           = 8'd0;
        res_ovf            = overflow_reg;
        flush_need         = 1'b0;
        ram_we             = 1'b0;
        unquoted           = 1'b0;
        is_content         = 1'b0;
        is_end             = 1'b0;
        mode_eff           = mode_reg;

        if (s_command == csvft_pkg::CMD_LINE_END) begin
            res_valid = 1'b1;
            if (mode_reg == csvft_pkg::MODE_SKIP
                || (mode_reg == csvft_pkg::MODE_UNDECIDED && skip_reg)) begin
                res_kind = csvft_pkg::KIND_SKIPPED;
                res_ovf  = 1'b0;
            end else begin
                res_kind = csvft_pkg::KIND_LINE_END;
            end
            in_quotes_next     = 1'b0;
            quote_pending_next = 1'b0;
            field_started_next = 1'b0;
            mode_next          = csvft_pkg::MODE_UNDECIDED;
            cnt_next           = '0;
            overflow_next      = 1'b0;
        end else begin
            // the first non-space byte decides the line
            if (mode_reg == csvft_pkg::MODE_UNDECIDED && !c_ws) begin
                if (s_char_byte == csvft_pkg::CHAR_HASH && skip_reg) begin
                    mode_eff = csvft_pkg::MODE_SKIP;
                end else begin
                    mode_eff = csvft_pkg::MODE_NORMAL;
                end
            end
            mode_next = mode_eff;

            if (mode_eff != csvft_pkg::MODE_SKIP) begin
                if (quote_pending_reg) begin
                    quote_pending_next = 1'b0;
                    if (s_char_byte == csvft_pkg::CHAR_QUOTE) begin
                        is_content = 1'b1;
                    end else begin
                        in_quotes_next = 1'b0;
                        unquoted       = 1'b1;
                    end
                end else if (in_quotes_reg) begin
                    if (s_char_byte == csvft_pkg::CHAR_QUOTE) begin
                        quote_pending_next = 1'b1;
                    end else begin
                        is_content = 1'b1;
                    end
                end else begin
                    unquoted = 1'b1;
                end

                if (unquoted) begin
                    if (s_char_byte == csvft_pkg::CHAR_QUOTE) begin
                        in_quotes_next = 1'b1;
                    end else if (s_char_byte == csvft_pkg::CHAR_COMMA) begin
                        is_end = 1'b1;
                    end else begin
                        is_content = 1'b1;
                    end
                end
            end

            if (is_end) begin
                res_valid          = 1'b1;
                res_kind           = csvft_pkg::KIND_FIELD_END;
                cnt_next           = '0;
                overflow_next      = 1'b0;
                field_started_next = 1'b0;
            end

            if (is_content) begin
                if (c_ws) begin
                    // leading space is dropped, trailing space is held
                    if (field_started_reg) begin
                        if (cnt_reg < DEPTH_C) begin
                            ram_we   = 1'b1;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end else begin
                            overflow_next = 1'b1;
                        end
                    end
                end else begin
                    field_started_next = 1'b1;
                    cnt_next           = '0;
                    if (cnt_reg != '0) begin
                        flush_need = 1'b1;
                    end else begin
                        res_valid = 1'b1;
                        res_byte  = s_char_byte;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg          <= 1'b1;
            in_quotes_reg     <= 1'b0;
            quote_pending_reg <= 1'b0;
            field_started_reg <= 1'b0;
            mode_reg          <= csvft_pkg::MODE_UNDECIDED;
            cnt_reg           <= '0;
            overflow_reg      <= 1'b0;
            ptr_reg           <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                skip_reg <= cfg_wr_data;
            end
            if (cmd.accept) begin
                in_quotes_reg     <= in_quotes_next;
                quote_pending_reg <= quote_pending_next;
                field_started_reg <= field_started_next;
                mode_reg          <= mode_next;
                cnt_reg           <= cnt_next;
                overflow_reg      <= overflow_next;
                ptr_reg           <= '0;
            end else if (cmd.ptr_inc) begin
                ptr_reg <= ptr_reg + CNT_W'(1);
            end
            if (cmd.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            char_reg      <= s_char_byte;
            flush_len_reg <= cnt_reg;
            emit_ovf_reg  <= overflow_reg;
        end
        if (cmd.load) begin
            case (cmd.out_sel)
                csvft_pkg::SEL_HELD: begin
                    m_byte_reg <= ram_rdata;
                    m_kind_reg <= csvft_pkg::KIND_DATA;
                    m_last_reg <= 1'b0;
                    m_ovf_reg  <= emit_ovf_reg;
                end
                csvft_pkg::SEL_CHAR: begin
                    m_byte_reg <= char_reg;
                    m_kind_reg <= csvft_pkg::KIND_DATA;
                    m_last_reg <= 1'b1;
                    m_ovf_reg  <= emit_ovf_reg;
                end
                default: begin
                    m_byte_reg <= res_byte;
                    m_kind_reg <= res_kind;
                    m_last_reg <= 1'b1;
                    m_ovf_reg  <= res_ovf;
                end
            endcase
        end
    end

    csvft_ram #(
        .WIDTH (8),
        .DEPTH (HELD_SPACE_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_held_ram (
        .aclk   (aclk),
        .wr_en  (ram_we && cmd.accept),
        .wr_addr(cnt_reg[ADDR_W-1:0]),
        .wr_data(s_char_byte),
        .rd_en  (cmd.rd_en),
        .rd_addr(ptr_reg[ADDR_W-1:0]),
        .rd_data(ram_rdata)
    );

    assign status.out_free   = !m_valid_reg || m_ready;
    assign status.has_result = res_valid;
    assign status.flush_need = flush_need;
    assign status.held_last  = (ptr_reg + CNT_W'(1)) == flush_len_reg;

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_byte_reg;
    assign m_result_kind = m_kind_reg;
    assign m_last_result = m_last_reg;
    assign m_ws_overflow = m_ovf_reg;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= DEPTH_C)
        else $error("held space count beyond buffer depth");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && flush_need) |=> (cnt_reg == '0 && field_started_reg
                                         && flush_len_reg != '0))
        else $error("flush start left held space state inconsistent");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten while a request is pending");

    a_skip_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == csvft_pkg::MODE_SKIP) |-> (!in_quotes_reg && cnt_reg == '0
                                                  && !field_started_reg))
        else $error("skipped line carries field state");
`endif

endmodule

>>> rtl/core/csv_field_tokenizer.sv
// Streaming CSV line tokenizer: unquotes fields, trims whitespace and
// marks field and line ends.
//
// Input channel (s_valid/s_ready): one request per line byte
// (s_command = 0, byte on s_char_byte) or one end-of-line request
// (s_command = 1). Output channel (m_valid/m_ready): data bytes, field
// end, last field end or line-skipped results; m_last_result flags the
// final result of each input request.
// A result is loaded into the output register when its request is
// accepted. A non-space byte after n held trailing spaces starts a
// flush: each held byte is read from the held-space buffer, which has
// a registered read port, and then loaded into the output register;
// the byte itself comes last, and s_ready stays low until the flush
// ends. skip_comment_lines is written through cfg_wr_en/cfg_wr_data
// while idle; the user must ensure this, the block does not. Reset
// clears all line state and sets skip_comment_lines to 1; no result
// is pending after reset. When the receiver stalls, the output
// register holds its result and s_ready drops until it is taken.
`timescale 1ns / 1ps

module csv_field_tokenizer #(
    parameter int HELD_SPACE_DEPTH = 15
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    input  logic [7:0] s_char_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_result_kind,
    output logic       m_last_result,
    output logic       m_ws_overflow
);

    csvft_pkg::ctrl_cmd_t  cmd;
    csvft_pkg::dp_status_t status;

    csvft_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .status (status),
        .cmd    (cmd)
    );

    csvft_dp #(
        .HELD_SPACE_DEPTH(HELD_SPACE_DEPTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_command    (s_command),
        .s_char_byte  (s_char_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_result_kind(m_result_kind),
        .m_last_result(m_last_result),
        .m_ws_overflow(m_ws_overflow),
        .cmd          (cmd),
        .status       (status)
    );

endmodule
